/* rtl/magic_length_crc_frame_parser_defines.svh */
// assertion macros for the frame parser
// used at the end of the top level; expects clk and rst_n in scope
`ifndef MAGIC_LENGTH_CRC_FRAME_PARSER_DEFINES_SVH
`define MAGIC_LENGTH_CRC_FRAME_PARSER_DEFINES_SVH

// same-cycle implication
`define MLCFP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MLCFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/mlcfp_pkg.sv */
// shared types, codes and the crc step for the frame parser
// no dependencies
package mlcfp_pkg;

  localparam int MAX_PAYLOAD_DEF  = 64;
  localparam int WINDOW_DEPTH_DEF = 128;
  localparam int RESULT_CAP       = 64;

  localparam logic [1:0] CFG_MAGIC_FIRST  = 2'd0;
  localparam logic [1:0] CFG_MAGIC_SECOND = 2'd1;
  localparam logic [1:0] CFG_MAX_LEN      = 2'd2;

  localparam logic [7:0] MAGIC_FIRST_RST  = 8'hA5;
  localparam logic [7:0] MAGIC_SECOND_RST = 8'h5A;
  localparam logic [6:0] MAX_LEN_RST      = 7'd64;

  localparam logic [1:0] EV_PAYLOAD = 2'd0;
  localparam logic [1:0] EV_EMPTY   = 2'd1;
  localparam logic [1:0] EV_LEN_ERR = 2'd2;
  localparam logic [1:0] EV_CRC_ERR = 2'd3;

  localparam logic [2:0] OFF_HOLD  = 3'd0;
  localparam logic [2:0] OFF_ZERO  = 3'd1;
  localparam logic [2:0] OFF_TWO   = 3'd2;
  localparam logic [2:0] OFF_THREE = 3'd3;
  localparam logic [2:0] OFF_INC   = 3'd4;

  localparam logic [2:0] DROP_NONE  = 3'd0;
  localparam logic [2:0] DROP_PREV  = 3'd1;
  localparam logic [2:0] DROP_TAIL  = 3'd2;
  localparam logic [2:0] DROP_ONE   = 3'd3;
  localparam logic [2:0] DROP_FRAME = 3'd4;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef struct packed {
    logic       wr_in;
    logic       clr_n;
    logic [2:0] off_op;
    logic       rd;
    logic       prev_upd;
    logic       len_ld;
    logic       crc_init;
    logic       crc_upd;
    logic       rxlo_ld;
    logic       emit;
    logic [1:0] emit_kind;
    logic [2:0] drop;
  } cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic fill_lt3;
    logic pair_hit;
    logic scan_more;
    logic len_bad;
    logic frame_short;
    logic budget_full;
    logic frame_over;
    logic off_at_end;
    logic crc_ok;
    logic len_zero;
    logic out_free;
  } stat_t;

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* rtl/mlcfp_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module mlcfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/mlcfp_dp.sv */
// datapath: config registers, circular byte window, crc, counters, output register
// depends on mlcfp_pkg and mlcfp_ram
module mlcfp_dp #(
  parameter int MAX_PAYLOAD  = mlcfp_pkg::MAX_PAYLOAD_DEF,
  parameter int WINDOW_DEPTH = mlcfp_pkg::WINDOW_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_wdata,
  input  logic [7:0]         in_byte,
  input  mlcfp_pkg::cmd_t    cmd,
  output mlcfp_pkg::stat_t   stat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_byte,
  output logic [6:0]         out_len,
  output logic               out_last
);
  import mlcfp_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int EW = (CW > 9) ? CW + 1 : 10;
  localparam int CAP_A = (MAX_PAYLOAD < WINDOW_DEPTH - 5) ? MAX_PAYLOAD : WINDOW_DEPTH - 5;
  localparam int LIM_CAP = (CAP_A < RESULT_CAP) ? CAP_A : RESULT_CAP;

  logic [7:0]    magic_first_r, magic_second_r;
  logic [6:0]    max_len_r;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] off_r, off_nxt;
  logic          prev_mf_r;
  logic [7:0]    len_r;
  logic [15:0]   crc_r;
  logic [7:0]    rxlo_r;
  logic [6:0]    n_r;
  logic          out_valid_r;
  logic [1:0]    kind_r;
  logic [7:0]    byte_r;
  logic [6:0]    olen_r;
  logic          last_r;

  logic [7:0]    rdata;
  logic [7:0]    lim;
  logic [CW-1:0] drop_amt;
  logic [AW-1:0] waddr, raddr;
  logic          out_free;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= (CW+1)'(WINDOW_DEPTH)) begin
      s = s - (CW+1)'(WINDOW_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign waddr = wrap_add(head_r, fill_r);
  assign raddr = wrap_add(head_r, off_r);

  mlcfp_ram #(.WIDTH(8), .DEPTH(WINDOW_DEPTH)) u_win (
    .clk   (clk),
    .we    (cmd.wr_in && (fill_r < CW'(WINDOW_DEPTH))),
    .waddr (waddr),
    .wdata (in_byte),
    .re    (cmd.rd),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign lim = ({1'b0, max_len_r} < 8'(LIM_CAP)) ? {1'b0, max_len_r} : 8'(LIM_CAP);
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    stat.fill_zero   = (fill_r == '0);
    stat.fill_lt3    = (fill_r < CW'(3));
    stat.pair_hit    = (off_r != '0) && prev_mf_r && (rdata == magic_second_r);
    stat.scan_more   = (EW'(off_r) + EW'(1)) < EW'(fill_r);
    stat.len_bad     = rdata > lim;
    stat.frame_short = EW'(fill_r) < (EW'(rdata) + EW'(5));
    stat.budget_full = n_r >= 7'(RESULT_CAP);
    stat.frame_over  = (9'(n_r) + ((len_r == '0) ? 9'd1 : 9'(len_r))) > 9'(RESULT_CAP);
    stat.off_at_end  = EW'(off_r) == (EW'(len_r) + EW'(2));
    stat.crc_ok      = {rdata, rxlo_r} == crc_r;
    stat.len_zero    = (len_r == '0);
    stat.out_free    = out_free;
  end

  always_comb begin
    case (cmd.drop)
      DROP_PREV:  drop_amt = off_r - CW'(1);
      DROP_TAIL:  drop_amt = (rdata == magic_first_r) ? fill_r - CW'(1) : fill_r;
      DROP_ONE:   drop_amt = CW'(1);
      DROP_FRAME: drop_amt = CW'(len_r) + CW'(5);
      default:    drop_amt = '0;
    endcase
  end

  always_comb begin
    head_nxt = wrap_add(head_r, drop_amt);
    fill_nxt = fill_r - drop_amt;
    if (cmd.wr_in && (fill_r < CW'(WINDOW_DEPTH))) begin
      fill_nxt = fill_r + CW'(1);
    end
  end

  always_comb begin
    case (cmd.off_op)
      OFF_ZERO:  off_nxt = '0;
      OFF_TWO:   off_nxt = CW'(2);
      OFF_THREE: off_nxt = CW'(3);
      OFF_INC:   off_nxt = off_r + CW'(1);
      default:   off_nxt = off_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_first_r  <= MAGIC_FIRST_RST;
      magic_second_r <= MAGIC_SECOND_RST;
      max_len_r      <= MAX_LEN_RST;
      head_r         <= '0;
      fill_r         <= '0;
      off_r          <= '0;
      n_r            <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAGIC_FIRST:  magic_first_r  <= cfg_wdata;
          CFG_MAGIC_SECOND: magic_second_r <= cfg_wdata;
          CFG_MAX_LEN:      max_len_r      <= cfg_wdata[6:0];
          default:          ;
        endcase
      end
      head_r <= head_nxt;
      fill_r <= fill_nxt;
      off_r  <= off_nxt;
      if (cmd.clr_n) begin
        n_r <= '0;
      end else if (cmd.emit) begin
        n_r <= n_r + 7'd1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prev_upd) begin
      prev_mf_r <= (rdata == magic_first_r);
    end
    if (cmd.len_ld) begin
      len_r <= rdata;
    end
    if (cmd.crc_init) begin
      crc_r <= CRC_INIT;
    end else if (cmd.crc_upd) begin
      crc_r <= crc16_step(crc_r, rdata);
    end
    if (cmd.rxlo_ld) begin
      rxlo_r <= rdata;
    end
    if (cmd.emit) begin
      kind_r <= cmd.emit_kind;
      byte_r <= (cmd.emit_kind == EV_PAYLOAD) ? rdata : 8'h00;
      olen_r <= ((cmd.emit_kind == EV_PAYLOAD) || (cmd.emit_kind == EV_EMPTY)) ?
                len_r[6:0] : 7'd0;
      last_r <= (cmd.emit_kind != EV_PAYLOAD) || stat.off_at_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = kind_r;
  assign out_byte  = byte_r;
  assign out_len   = olen_r;
  assign out_last  = last_r;

endmodule

/* rtl/mlcfp_ctrl.sv */
// controller: sequences scan, length check, crc, trailer check and emit
// depends on mlcfp_pkg
module mlcfp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  mlcfp_pkg::stat_t stat,
  output mlcfp_pkg::cmd_t  cmd
);
  import mlcfp_pkg::*;

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_SCAN_RD    = 4'd1;
  localparam logic [3:0] S_SCAN_CHK   = 4'd2;
  localparam logic [3:0] S_HDR        = 4'd3;
  localparam logic [3:0] S_LEN_CHK    = 4'd4;
  localparam logic [3:0] S_CRC_RD     = 4'd5;
  localparam logic [3:0] S_CRC_UPD    = 4'd6;
  localparam logic [3:0] S_TLO_RD     = 4'd7;
  localparam logic [3:0] S_TLO        = 4'd8;
  localparam logic [3:0] S_THI        = 4'd9;
  localparam logic [3:0] S_EMIT_LEN   = 4'd10;
  localparam logic [3:0] S_EMIT_CRC   = 4'd11;
  localparam logic [3:0] S_EMIT_EMPTY = 4'd12;
  localparam logic [3:0] S_PAY_RD     = 4'd13;
  localparam logic [3:0] S_PAY_EMIT   = 4'd14;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.wr_in  = 1'b1;
          cmd.clr_n  = 1'b1;
          cmd.off_op = OFF_ZERO;
          state_nxt  = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (stat.fill_zero) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        cmd.prev_upd = 1'b1;
        if (stat.pair_hit) begin
          cmd.drop   = DROP_PREV;
          cmd.off_op = OFF_TWO;
          state_nxt  = S_HDR;
        end else if (stat.scan_more) begin
          cmd.off_op = OFF_INC;
          state_nxt  = S_SCAN_RD;
        end else begin
          // no pair: keep only a trailing first magic byte
          cmd.drop  = DROP_TAIL;
          state_nxt = S_IDLE;
        end
      end
      S_HDR: begin
        if (stat.fill_lt3) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_LEN_CHK;
        end
      end
      S_LEN_CHK: begin
        cmd.len_ld = 1'b1;
        if (stat.len_bad) begin
          state_nxt = stat.budget_full ? S_IDLE : S_EMIT_LEN;
        end else if (stat.frame_short) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.crc_init = 1'b1;
          state_nxt    = S_CRC_RD;
        end
      end
      S_CRC_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CRC_UPD;
      end
      S_CRC_UPD: begin
        cmd.crc_upd = 1'b1;
        cmd.off_op  = OFF_INC;
        state_nxt   = stat.off_at_end ? S_TLO_RD : S_CRC_RD;
      end
      S_TLO_RD: begin
        cmd.rd     = 1'b1;
        cmd.off_op = OFF_INC;
        state_nxt  = S_TLO;
      end
      S_TLO: begin
        cmd.rxlo_ld = 1'b1;
        cmd.rd      = 1'b1;
        state_nxt   = S_THI;
      end
      S_THI: begin
        if (!stat.crc_ok) begin
          state_nxt = stat.budget_full ? S_IDLE : S_EMIT_CRC;
        end else if (stat.frame_over) begin
          state_nxt = S_IDLE;
        end else if (stat.len_zero) begin
          state_nxt = S_EMIT_EMPTY;
        end else begin
          cmd.off_op = OFF_THREE;
          state_nxt  = S_PAY_RD;
        end
      end
      S_EMIT_LEN, S_EMIT_CRC: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = (state_r == S_EMIT_LEN) ? EV_LEN_ERR : EV_CRC_ERR;
          cmd.drop      = DROP_ONE;
          cmd.off_op    = OFF_ZERO;
          state_nxt     = S_SCAN_RD;
        end
      end
      S_EMIT_EMPTY: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = EV_EMPTY;
          cmd.drop      = DROP_FRAME;
          cmd.off_op    = OFF_ZERO;
          state_nxt     = S_SCAN_RD;
        end
      end
      S_PAY_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_PAY_EMIT;
      end
      S_PAY_EMIT: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = EV_PAYLOAD;
          if (stat.off_at_end) begin
            cmd.drop   = DROP_FRAME;
            cmd.off_op = OFF_ZERO;
            state_nxt  = S_SCAN_RD;
          end else begin
            cmd.off_op = OFF_INC;
            state_nxt  = S_PAY_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/magic_length_crc_frame_parser.sv */
// Length-prefixed frame parser with CRC-16/Modbus check.
// in_*: one received byte per beat. The byte goes into a circular window
// held in a RAM; the parser then rescans the window from its front for the
// magic pair, checks the length byte and, once a whole frame is present,
// runs the crc over length and payload, one RAM read per byte.
// out_*: one event per beat: payload bytes of a good frame (tlast on the
// final one), an empty-frame event, or a length or crc error event.
// cfg_*: register writes; the user must write only while the parser is idle,
// which the block itself does not enforce. Each step is one RAM read followed by
// use of the read data: for each scanned window byte, the length check, each crc
// byte, the trailer bytes and each payload byte. After every error or empty event
// and the final payload byte the window is rescanned from its front; a short
// frame ends the parse right after the length check. in_tready is high only
// while the parser waits for the next byte, so bytes are taken one parse at a time.
// Reset clears the window to empty and loads the register reset values.
// A stalled receiver holds the pending event in the output register and the
// parser waits at its next event until that beat is taken.
module magic_length_crc_frame_parser #(
  parameter int MAX_PAYLOAD  = mlcfp_pkg::MAX_PAYLOAD_DEF,
  parameter int WINDOW_DEPTH = mlcfp_pkg::WINDOW_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [14:8] payload_length, [15] zero
  output logic [1:0]  out_tuser,  // [1:0] event_kind
  output logic        out_tlast
);
  import mlcfp_pkg::*;

  cmd_t       cmd;
  stat_t      stat;
  logic [7:0] obyte;
  logic [6:0] olen;

  mlcfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mlcfp_dp #(
    .MAX_PAYLOAD  (MAX_PAYLOAD),
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_byte   (in_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_byte  (obyte),
    .out_len   (olen),
    .out_last  (out_tlast)
  );

  assign out_tdata = {1'b0, olen, obyte};

`include "magic_length_crc_frame_parser_defines.svh"

  `MLCFP_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready after accept")
  `MLCFP_ASSERT_IMPL(a_emit_into_free, cmd.emit, stat.out_free, "emit into a full output register")
  `MLCFP_ASSERT_IMPL(a_err_is_last, out_tvalid && (out_tuser == EV_LEN_ERR || out_tuser == EV_CRC_ERR), out_tlast && (out_tdata == 16'h0000), "bad error event")

endmodule

/* tb/tb_magic_length_crc_frame_parser.sv */
// self-checking bench for the magic/length/crc frame parser
// depends on mlcfp_pkg and magic_length_crc_frame_parser
`timescale 1ns / 100ps

class frame_event_board;
  // window model and register copies
  logic [7:0] win [$];
  logic [7:0] mfirst, msecond;
  logic [6:0] maxlen;
  logic [17:0] pending [$];  // {kind, byte, len, last}
  int errors;

  function new();
    mfirst = mlcfp_pkg::MAGIC_FIRST_RST;
    msecond = mlcfp_pkg::MAGIC_SECOND_RST;
    maxlen = mlcfp_pkg::MAX_LEN_RST;
    errors = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [7:0] val);
    if (idx == mlcfp_pkg::CFG_MAGIC_FIRST) mfirst = val;
    else if (idx == mlcfp_pkg::CFG_MAGIC_SECOND) msecond = val;
    else if (idx == mlcfp_pkg::CFG_MAX_LEN) maxlen = val[6:0];
  endfunction

  function logic [15:0] crc_over(int len);
    logic [15:0] c;
    c = 16'hFFFF;
    for (int i = 0; i <= len; i++) begin
      c ^= {8'h00, win[2 + i]};
      for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  function void drop(int n);
    for (int i = 0; i < n && win.size() > 0; i++) void'(win.pop_front());
  endfunction

  function void add(logic [1:0] k, logic [7:0] b, logic [6:0] l, logic t);
    pending.push_back({k, b, l, t});
  endfunction

  // note one accepted input byte and queue the events it causes
  function void note_byte(logic [7:0] d);
    int lim, n, i, len;
    bit found;
    logic [15:0] rx;
    lim = maxlen;
    if (lim > 64) lim = 64;
    n = 0;
    if (win.size() < 128) win.push_back(d);
    forever begin
      if (win.size() == 0) break;
      found = 0;
      for (i = 0; i + 1 < win.size(); i++)
        if (win[i] == mfirst && win[i + 1] == msecond) begin
          found = 1;
          break;
        end
      if (found) drop(i);
      else begin
        if (win[win.size() - 1] == mfirst) drop(win.size() - 1);
        else drop(win.size());
        break;
      end
      if (win.size() < 3) break;
      len = win[2];
      if (len > lim) begin
        if (n >= 64) break;
        add(mlcfp_pkg::EV_LEN_ERR, 8'h00, 7'd0, 1'b1); n++;
        drop(1);
        continue;
      end
      if (win.size() < len + 5) break;
      rx = {win[4 + len], win[3 + len]};
      if (crc_over(len) != rx) begin
        if (n >= 64) break;
        add(mlcfp_pkg::EV_CRC_ERR, 8'h00, 7'd0, 1'b1); n++;
        drop(1);
        continue;
      end
      if (n + (len ? len : 1) > 64) break;
      if (len == 0) begin
        add(mlcfp_pkg::EV_EMPTY, 8'h00, 7'd0, 1'b1); n++;
      end else
        for (int k = 0; k < len; k++) begin
          add(mlcfp_pkg::EV_PAYLOAD, win[3 + k], 7'(len), k + 1 == len); n++;
        end
      drop(len + 5);
    end
  endfunction

  function void check_event(logic [1:0] k, logic [7:0] b, logic [6:0] l, logic t);
    logic [17:0] got, want;
    got = {k, b, l, t};
    if (pending.size() == 0) begin
      $display("%0t: unexpected beat, expected none, actual %h", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (want[17:16] != k) begin
      $display("%0t: kind expected %0d actual %0d", $time, want[17:16], k); errors++;
    end
    if (want[15:8] != b) begin
      $display("%0t: byte expected %h actual %h", $time, want[15:8], b); errors++;
    end
    if (want[7:1] != l) begin
      $display("%0t: length expected %0d actual %0d", $time, want[7:1], l); errors++;
    end
    if (want[0] != t) begin
      $display("%0t: last expected %0d actual %0d", $time, want[0], t); errors++;
    end
  endfunction
endclass

module tb_magic_length_crc_frame_parser;
  import mlcfp_pkg::*;

  logic clk, rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;
  logic in_tvalid, in_tready, out_tvalid, out_tready, out_tlast;
  logic [7:0] in_tdata;
  logic [15:0] out_tdata;
  logic [1:0] out_tuser;
  int send_idle, recv_idle;
  longint cycles;
  frame_event_board board;

  magic_length_crc_frame_parser dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 3000000) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // receiver: random stall, check on each accepted beat
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_event(out_tuser, out_tdata[7:0], out_tdata[14:8], out_tlast);
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send_byte(logic [7:0] d);
    while ($urandom_range(99) < send_idle) @(posedge clk);
    in_tvalid <= 1;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    board.note_byte(d);
    in_tvalid <= 0;
    // the parser is busy after each accepted beat
    @(posedge clk);
  endtask

  task automatic wait_drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    board.set_reg(idx, val);
    @(posedge clk);
  endtask

  // whole frame with good or damaged crc
  task automatic send_frame(int len, bit bad);
    logic [7:0] body [$];
    logic [15:0] c;
    body.push_back(8'(len));
    for (int i = 0; i < len; i++) body.push_back(8'($urandom));
    c = 16'hFFFF;
    foreach (body[i]) begin
      c ^= {8'h00, body[i]};
      for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    if (bad) c ^= 16'h1 << $urandom_range(15);
    send_byte(board.mfirst);
    send_byte(board.msecond);
    foreach (body[i]) send_byte(body[i]);
    send_byte(c[7:0]);
    send_byte(c[15:8]);
  endtask

  task automatic random_phase(int items);
    int sent, r, len;
    sent = 0;
    while (sent < items) begin
      r = $urandom_range(9);
      len = ($urandom_range(9) == 0) ? int'(board.maxlen) : int'($urandom_range(6));
      if (r < 6) begin
        send_frame(len, 0); sent += len + 5;
      end else if (r == 6) begin
        send_frame(len, 1); sent += len + 5;
      end else if (r == 7) begin
        send_byte(board.mfirst); send_byte(board.msecond);
        send_byte(8'h80 | 8'($urandom)); sent += 3;
      end else begin
        send_byte(8'($urandom)); sent++;
      end
    end
  endtask

  initial begin
    board = new();
    rst_n = 0;
    cfg_we = 0; cfg_index = 0; cfg_wdata = 0;
    in_tvalid = 0; in_tdata = 0;
    send_idle = 0; recv_idle = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty frame, byte extremes, a crc error, length above the limit
    send_frame(0, 0);
    send_frame(2, 0);
    send_byte(8'h00); send_byte(8'hFF); send_byte(board.mfirst);
    send_frame(1, 1);
    send_byte(board.mfirst); send_byte(board.msecond); send_byte(8'd65);
    wait_drain();
    write_reg(CFG_MAX_LEN, 8'd127);
    send_byte(board.mfirst); send_byte(board.msecond); send_byte(8'd100);
    wait_drain();

    send_idle = 35; recv_idle = 67;
    write_reg(CFG_MAGIC_FIRST, 8'h00);
    write_reg(CFG_MAGIC_SECOND, 8'hFF);
    write_reg(CFG_MAX_LEN, 8'd0);
    random_phase(15);
    wait_drain();

    send_idle = 67; recv_idle = 35;
    write_reg(CFG_MAGIC_FIRST, 8'hFF);
    write_reg(CFG_MAGIC_SECOND, 8'hFF);
    write_reg(CFG_MAX_LEN, 8'd5);
    random_phase(15);
    wait_drain();

    send_idle = 0; recv_idle = 0;
    write_reg(CFG_MAGIC_FIRST, 8'hA5);
    write_reg(CFG_MAGIC_SECOND, 8'h5A);
    write_reg(CFG_MAX_LEN, 8'd64);
    random_phase(5);
    send_frame(64, 0);
    wait_drain();

    if (board.errors == 0 && board.pending.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

/* filelist.f */
+incdir+rtl
rtl/mlcfp_pkg.sv
rtl/mlcfp_ram.sv
rtl/mlcfp_dp.sv
rtl/mlcfp_ctrl.sv
rtl/magic_length_crc_frame_parser.sv
tb/tb_magic_length_crc_frame_parser.sv
